/* src/pdag_eoc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdag_eoc_pkg
// Shared types and constants for the PDAG orientation closure core.
// ----------------------------------------------------------------------------
package pdag_eoc_pkg;

  localparam int NODES   = 16;
  localparam int IDX_W   = $clog2(NODES);
  localparam int CNT_W   = 5;
  localparam int IN_W    = 40;

  typedef logic [NODES-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_PREP,
    OP_ORIENT
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t op;
    idx_t     x;
    idx_t     y;
    row_t     u;
    row_t     d;
    row_t     mask;
    idx_t     sel_b;
    idx_t     sel_c;
    idx_t     sel_d;
  } cell_cmd_t;

  // column bits picked out of one cell
  typedef struct packed {
    logic ub;
    logic db;
    logic uc;
    logic dc;
    logic ud;
    logic dd;
  } cell_col_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_R1,
    ST_R2,
    ST_R3S,
    ST_R3D,
    ST_R4,
    ST_EMIT
  } state_t;

endpackage

/* src/pdag_eoc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdag_eoc_cell
// One matrix row: undirected and directed marks, load, symmetry fix-up and
// edge orientation, plus column taps for the rule evaluation.
// ----------------------------------------------------------------------------
module pdag_eoc_cell
  import pdag_eoc_pkg::*;
(
  input  logic      clk,
  input  idx_t      cell_idx,
  input  cell_cmd_t cmd,
  input  row_t      tcol,
  output row_t      urow,
  output row_t      drow,
  output cell_col_t col
);

  row_t u;
  row_t d;
  row_t u_next;
  row_t d_next;

  always_comb begin
    u_next = u;
    d_next = d;
    unique case (cmd.op)
      OP_LOAD: begin
        if (cell_idx == cmd.x) begin
          u_next = cmd.u;
          d_next = cmd.d;
        end
      end
      OP_PREP: begin
        // rows outside the active node range keep their marks
        if (cmd.mask[cell_idx]) begin
          u_next = u & cmd.mask & tcol;
          d_next = (d | (u & ~tcol)) & cmd.mask;
        end
      end
      OP_ORIENT: begin
        // mirror write last: orienting a diagonal entry leaves it empty
        if (cell_idx == cmd.x) begin
          u_next[cmd.y] = 1'b0;
          d_next[cmd.y] = 1'b1;
        end
        if (cell_idx == cmd.y) begin
          u_next[cmd.x] = 1'b0;
          d_next[cmd.x] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u <= u_next;
    d <= d_next;
  end

  assign urow   = u;
  assign drow   = d;
  assign col.ub = u[cmd.sel_b];
  assign col.db = d[cmd.sel_b];
  assign col.uc = u[cmd.sel_c];
  assign col.dc = d[cmd.sel_c];
  assign col.ud = u[cmd.sel_d];
  assign col.dd = d[cmd.sel_d];

endmodule

/* src/pdag_edge_orientation_closure_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdag_edge_orientation_closure_core
// Meek rule R1-R4 orientation closure over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
// Rows are loaded one per request. A request with tlast set starts the
// closure: a fix-up step, then repeated passes until a pass orients
// nothing. Each pass walks every index triple for R1, R2 and R4, and every
// index pair for R3 with a scan over the n nodes for each undirected pair,
// all by the single rule evaluator walking the index loops one step a cycle
// over the row of cells. The closed matrix is then sent as n rows, one a
// cycle while the sink is ready. No new row is taken during closure.
module pdag_edge_orientation_closure_core
  import pdag_eoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,  // row_index[3:0], undirected_bits[19:4],
                                      // directed_bits[35:20], zero pad
  input  logic              s_tlast,  // last_row
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [IN_W-1:0]   m_tdata,  // out_row_index[3:0], out_undirected_bits
                                      // [19:4], out_directed_bits[35:20], pad
  output logic              m_tlast   // out_last
);

  state_t    state, state_next;
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] n_eff;
  idx_t      nm1;
  row_t      mask;
  idx_t      a, b, c, d;
  logic      pass_changed;
  row_t      mem;
  logic      r3_act;
  cell_cmd_t cmd;
  row_t      ur [NODES];
  row_t      dr [NODES];
  row_t      tcol [NODES];
  cell_col_t col [NODES];
  row_t      cub, cdb, cuc, cdc, cud, cdd;
  logic      hit;
  logic      last2, last3;
  logic      s_acc;
  logic      out_load;
  row_t      in_u, in_d;
  idx_t      in_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(NODES);
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  always_comb begin
    if (node_count == '0) n_eff = CNT_W'(1);
    else if (node_count > CNT_W'(NODES)) n_eff = CNT_W'(NODES);
    else n_eff = node_count;
  end
  assign nm1  = idx_t'(n_eff - CNT_W'(1));
  assign mask = {NODES{1'b1}} >> (CNT_W'(NODES) - n_eff);

  assign in_row = s_tdata[IDX_W-1:0];
  assign in_u   = s_tdata[IDX_W +: NODES] & mask;
  assign in_d   = s_tdata[IDX_W+NODES +: NODES] & mask & ~in_u;

  genvar gi;
  generate
    for (gi = 0; gi < NODES; gi++) begin : g_cell
      pdag_eoc_cell u_cell (
        .clk      (clk),
        .cell_idx (idx_t'(gi)),
        .cmd      (cmd),
        .tcol     (tcol[gi]),
        .urow     (ur[gi]),
        .drow     (dr[gi]),
        .col      (col[gi])
      );
      assign cub[gi] = col[gi].ub;
      assign cdb[gi] = col[gi].db;
      assign cuc[gi] = col[gi].uc;
      assign cdc[gi] = col[gi].dc;
      assign cud[gi] = col[gi].ud;
      assign cdd[gi] = col[gi].dd;
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      for (int k = 0; k < NODES; k++) begin
        tcol[i][k] = ur[k][i];
      end
    end
  end

  assign last2 = (a == nm1) && (b == nm1);
  assign last3 = last2 && (c == nm1);
  assign s_acc = s_tvalid && s_tready;
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // rule evaluation on the current index step
  always_comb begin
    hit = 1'b0;
    unique case (state)
      ST_R1: hit = dr[a][b] && !ur[a][c] && !dr[a][c] && !ur[c][a] && !dr[c][a]
                   && ur[b][c];
      ST_R2: hit = ur[a][b] && dr[a][c] && dr[c][b];
      ST_R3D: hit = r3_act && mem[d] &&
                    (|(mem & ~(row_t'(1) << d) & ~ur[d] & ~dr[d] & ~cud & ~cdd & mask));
      ST_R4: hit = ur[a][b] && dr[c][b] &&
                   (ur[a][c] || dr[a][c] || ur[c][a] || dr[c][a]) &&
                   (|(cdc & ur[a] & ~ur[b] & ~dr[b] & ~cub & ~cdb & mask));
      default: hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_acc && s_tlast) state_next = ST_PREP;
      ST_PREP: state_next = ST_R1;
      ST_R1:   if (last3) state_next = ST_R2;
      ST_R2:   if (last3) state_next = ST_R3S;
      ST_R3S: begin
        if (ur[a][b]) state_next = ST_R3D;
        else if (last2) state_next = ST_R4;
      end
      ST_R3D: begin
        if (d == nm1) state_next = last2 ? ST_R4 : ST_R3S;
      end
      ST_R4: begin
        if (last3) state_next = (pass_changed || hit) ? ST_R1 : ST_EMIT;
      end
      ST_EMIT: if (out_load && (a == nm1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to the cell row
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cmd.op    = OP_NOP;
    cmd.x     = a;
    cmd.y     = b;
    cmd.u     = in_u;
    cmd.d     = in_d;
    cmd.mask  = mask;
    cmd.sel_b = b;
    cmd.sel_c = c;
    cmd.sel_d = d;
    unique case (state)
      ST_IDLE: begin
        cmd.x = in_row;
        if (s_acc && ({1'b0, in_row} < n_eff)) cmd.op = OP_LOAD;
      end
      ST_PREP: cmd.op = OP_PREP;
      ST_R1: begin
        cmd.x = b;
        cmd.y = c;
        if (hit) cmd.op = OP_ORIENT;
      end
      ST_R2, ST_R3D, ST_R4: if (hit) cmd.op = OP_ORIENT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      a            <= '0;
      b            <= '0;
      c            <= '0;
      d            <= '0;
      pass_changed <= 1'b0;
      r3_act       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      // new pass starts clean
      if ((state == ST_PREP) || (state == ST_R4 && last3)) pass_changed <= 1'b0;
      else if (hit) pass_changed <= 1'b1;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          a <= '0;
          b <= '0;
          c <= '0;
          d <= '0;
        end
        ST_R1, ST_R2, ST_R4: begin
          if (c == nm1) begin
            c <= '0;
            if (b == nm1) begin
              b <= '0;
              a <= (a == nm1) ? '0 : a + idx_t'(1);
            end else begin
              b <= b + idx_t'(1);
            end
          end else begin
            c <= c + idx_t'(1);
          end
        end
        ST_R3S: begin
          r3_act <= ur[a][b];
          mem    <= ur[a] & cdb & mask;
          d      <= '0;
          if (!ur[a][b]) begin
            if (b == nm1) begin
              b <= '0;
              a <= (a == nm1) ? '0 : a + idx_t'(1);
            end else begin
              b <= b + idx_t'(1);
            end
          end
        end
        ST_R3D: begin
          if (d == nm1) begin
            d <= '0;
            if (b == nm1) begin
              b <= '0;
              a <= (a == nm1) ? '0 : a + idx_t'(1);
            end else begin
              b <= b + idx_t'(1);
            end
          end else begin
            d <= d + idx_t'(1);
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            a <= (a == nm1) ? '0 : a + idx_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(IN_W - IDX_W - 2*NODES){1'b0}}, dr[a] & mask, ur[a] & mask, a};
      m_tlast <= (a == nm1);
    end
  end

endmodule
